// ----- design/mlf_pkg.sv -----
// Shared types and constants for the MAC learning forwarder.
// No dependencies; imported by mlf_cam and mac_learning_forwarder_top.
package mlf_pkg;

    localparam int MAC_W  = 48;
    localparam int PORT_W = 8;
    localparam int OP_W   = 2;
    localparam int ACT_W  = 2;

    // Individual/group bit of the first octet
    localparam int GROUP_BIT = 40;

    typedef enum logic [OP_W-1:0] {
        OP_LEARN   = 2'd0,
        OP_FORWARD = 2'd1,
        OP_CLEAR   = 2'd2
    } t_opcode;

    typedef enum logic [ACT_W-1:0] {
        ACT_TAP     = 2'd0,
        ACT_UNICAST = 2'd1,
        ACT_FLOOD   = 2'd2,
        ACT_CLEARED = 2'd3
    } t_action;

    // Table update command from the request decoder
    typedef struct packed {
        logic learn;
        logic clear;
    } t_cam_cmd;

endpackage

// ----- design/mlf_cam.sv -----
// Associative MAC table: entry registers, parallel match, learn/replace policy.
// Depends on mlf_pkg.
module mlf_cam #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mlf_pkg::t_cam_cmd          i_cmd,
    input  logic [mlf_pkg::MAC_W-1:0]  i_mac,
    input  logic [mlf_pkg::PORT_W-1:0] i_port,
    output logic                       o_hit,
    output logic [mlf_pkg::PORT_W-1:0] o_hit_port
);
    import mlf_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic [MAC_W-1:0]         r_entry_mac  [TABLE_ENTRIES];
    logic [PORT_W-1:0]        r_entry_port [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic [IDX_W-1:0]         r_ptr, n_ptr;

    logic [TABLE_ENTRIES-1:0] match_vec;
    logic [TABLE_ENTRIES-1:0] free_vec;
    logic [TABLE_ENTRIES-1:0] free_first;
    logic [TABLE_ENTRIES-1:0] ptr_onehot;
    logic [TABLE_ENTRIES-1:0] wr_sel;
    logic                     any_free;

    // Every cell compares against the lookup key
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            match_vec[i] = r_valid[i] && (r_entry_mac[i] == i_mac);
        end
    end

    // At most one entry matches, so an OR of masked ports selects it
    always_comb begin
        o_hit_port = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            o_hit_port = o_hit_port | (r_entry_port[i] & {PORT_W{match_vec[i]}});
        end
    end

    assign o_hit = |match_vec;

    // Lowest free slot: isolate the lowest set bit
    assign free_vec   = ~r_valid;
    assign free_first = free_vec & (~free_vec + 1'b1);
    assign any_free   = |free_vec;
    assign ptr_onehot = {{(TABLE_ENTRIES-1){1'b0}}, 1'b1} << r_ptr;

    always_comb begin
        wr_sel = '0;
        if (i_cmd.learn) begin
            if (o_hit) begin
                wr_sel = match_vec;
            end else if (any_free) begin
                wr_sel = free_first;
            end else begin
                wr_sel = ptr_onehot;
            end
        end
    end

    always_comb begin
        n_valid = r_valid | wr_sel;
        n_ptr   = r_ptr;
        if (i_cmd.clear) begin
            n_valid = '0;
            n_ptr   = '0;
        end else if (i_cmd.learn && !o_hit && !any_free) begin
            if (r_ptr == IDX_W'(TABLE_ENTRIES - 1)) begin
                n_ptr = '0;
            end else begin
                n_ptr = r_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ptr   <= '0;
        end else begin
            r_valid <= n_valid;
            r_ptr   <= n_ptr;
        end
    end

    // Entry payload, no reset
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (wr_sel[i]) begin
                r_entry_mac[i]  <= i_mac;
                r_entry_port[i] <= i_port;
            end
        end
    end

endmodule

// ----- design/mac_learning_forwarder_top.sv -----
// Layer-2 learning bridge table: learn, forward and clear requests.
// A taken request passes the request register and then the result register before its result strobe.
// Throughput: one request per cycle; busy stays low, the table update of one
// request is visible to the next at the same edge.
// Reset (synchronous, active low): all entries invalid, replacement pointer zero.
// Results cannot be stalled; each strobe lasts one cycle.
// Depends on mlf_pkg and mlf_cam.
module mac_learning_forwarder_top #(
    parameter int TABLE_ENTRIES = 64,
    parameter int PORT_COUNT    = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [mlf_pkg::OP_W-1:0]   i_opcode,
    input  logic [mlf_pkg::MAC_W-1:0]  i_mac_address,
    input  logic [mlf_pkg::PORT_W-1:0] i_session_port,
    output logic                       o_result_valid,
    output logic [mlf_pkg::ACT_W-1:0]  o_action,
    output logic [mlf_pkg::PORT_W-1:0] o_dest_port
);
    import mlf_pkg::*;

    // Request register
    logic              r_req_vld;
    logic [OP_W-1:0]   r_op;
    logic [MAC_W-1:0]  r_mac;
    logic [PORT_W-1:0] r_port;

    // Result register
    logic              r_res_vld, n_res_vld;
    logic [ACT_W-1:0]  r_action, n_action;
    logic [PORT_W-1:0] r_dest, n_dest;

    t_cam_cmd          cam_cmd;
    logic              cam_hit;
    logic [PORT_W-1:0] cam_port;
    logic              port_ok;

    // Pipeline of request and result registers: never stalls
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op   <= i_opcode;
            r_mac  <= i_mac_address;
            r_port <= i_session_port;
        end
    end

    // A session index outside the port range learns nothing
    assign port_ok = ({{(32-PORT_W){1'b0}}, r_port} < 32'(PORT_COUNT));

    assign cam_cmd.learn = r_req_vld && (r_op == OP_LEARN) && port_ok;
    assign cam_cmd.clear = r_req_vld && (r_op == OP_CLEAR);

    mlf_cam #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_cam (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cam_cmd),
        .i_mac      (r_mac),
        .i_port     (r_port),
        .o_hit      (cam_hit),
        .o_hit_port (cam_port)
    );

    // Result decode; the reserved opcode gives no result
    always_comb begin
        n_res_vld = r_req_vld;
        n_action  = ACT_TAP;
        n_dest    = '0;
        unique case (r_op)
            OP_LEARN: begin
                n_action = ACT_TAP;
            end
            OP_FORWARD: begin
                // Group addresses and unknown unicast flood
                if (!r_mac[GROUP_BIT] && cam_hit) begin
                    n_action = ACT_UNICAST;
                    n_dest   = cam_port;
                end else begin
                    n_action = ACT_FLOOD;
                end
            end
            OP_CLEAR: begin
                n_action = ACT_CLEARED;
            end
            default: begin
                n_res_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_dest   <= n_dest;
    end

    assign o_result_valid = r_res_vld;
    assign o_action       = r_action;
    assign o_dest_port    = r_dest;

endmodule
